@@ sv/tmfp_pkg.sv @@
// Package for the tagged message frame parser: field widths, result and
// error codes, and register indexes. No dependencies.
package tmfp_pkg;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int TAG_W      = 8;
    localparam int WORD_W     = 32;
    localparam int SIZE_W     = 28;
    localparam int OPC_W      = 4;
    localparam int KIND_W     = 2;
    localparam int ERR_W      = 2;
    localparam int IDX_W      = 2;

    // Bytes of the three tagged fields counted in the packet size.
    localparam logic [WORD_W:0] FIELD_BYTES = (WORD_W + 1)'(12);

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_DESC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BYTE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_UINT_TAG = 2'd0;
    localparam logic [ERR_W-1:0] ERR_STR_TAG  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_SIZE     = 2'd2;

    // Register indexes (byte address / 4).
    localparam logic [1:0] REG_HDR_TAG  = 2'd0;
    localparam logic [1:0] REG_UINT_TAG = 2'd1;
    localparam logic [1:0] REG_STR_TAG  = 2'd2;

endpackage

@@ sv/tmfp_byte_if.sv @@
// Input byte stream channel: valid/ready handshake with one byte payload.
// Depends on tmfp_pkg.
interface tmfp_byte_if
    import tmfp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TAG_W-1:0]  in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

@@ sv/tmfp_res_if.sv @@
// Result channel: valid/ready handshake carrying descriptor, message byte
// or error results. Depends on tmfp_pkg.
interface tmfp_res_if
    import tmfp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] src_id;
    logic [WORD_W-1:0] dest_id;
    logic [OPC_W-1:0]  opcode;
    logic [SIZE_W-1:0] packet_len;
    logic [SIZE_W-1:0] message_len;
    logic [TAG_W-1:0]  msg_byte;
    logic              last;
    logic [ERR_W-1:0]  error_code;

    modport source (output valid, output kind, output src_id, output dest_id,
                    output opcode, output packet_len, output message_len,
                    output msg_byte, output last, output error_code,
                    input ready);
    modport sink   (input valid, input kind, input src_id, input dest_id,
                    input opcode, input packet_len, input message_len,
                    input msg_byte, input last, input error_code,
                    output ready);
endinterface

@@ sv/tagged_message_frame_parser_top.sv @@
// Tagged message frame parser, top level.
// Depends on tmfp_pkg, tmfp_byte_if and tmfp_res_if.

// Takes one byte per transaction, one per clock cycle while results drain. Each
// accepted byte updates the parse state in the same cycle and, when it
// produces a result, loads the single output register; the next byte is
// taken while that result waits, as long as the register is empty or being
// drained, so i_byte.ready follows o_res.ready combinationally. A result
// appears in the cycle after the byte that causes it. Bytes are skipped until
// one matches the header tag; a big-endian header word follows (low 28 bits
// packet size, top 4 bits opcode), then source id, destination id and
// message size, each a uint tag and a big-endian word. The packet size must
// equal 12 plus the message size (compared at full width, no wrap). After
// the string tag a descriptor is emitted, then one result per message byte,
// the final one flagged last (the descriptor itself when the message is
// empty). A wrong tag or a size mismatch emits an error flagged last and
// returns to hunting; message bytes already emitted stay emitted. Tag
// registers sit at APB byte addresses 0, 4 and 8, reset to 0, and must only
// be written while the parser is idle.
module tagged_message_frame_parser_top
    import tmfp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tmfp_byte_if.sink             i_byte,
    tmfp_res_if.source            o_res,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata,
    output logic                  o_pready
);

    typedef enum logic [3:0] {
        PH_HUNT, PH_HDR, PH_TAG_SRC, PH_SRC, PH_TAG_DST, PH_DST,
        PH_TAG_LEN, PH_LEN, PH_TAG_STR, PH_MSG
    } t_phase;

    // Config registers
    logic [TAG_W-1:0]  r_hdr_tag, r_uint_tag, r_str_tag;

    // Parse state
    t_phase            r_phase, n_phase;
    logic [IDX_W-1:0]  r_byte_idx, n_byte_idx;
    logic [23:0]       r_field_word, n_field_word;   // bytes gathered so far
    logic [SIZE_W-1:0] r_hdr_size, n_hdr_size;
    logic [OPC_W-1:0]  r_hdr_opc, n_hdr_opc;
    logic [WORD_W-1:0] r_src_word, n_src_word;
    logic [WORD_W-1:0] r_dst_word, n_dst_word;
    logic [SIZE_W-1:0] r_len_word, n_len_word;       // only low bits survive
    logic [SIZE_W-1:0] r_remaining, n_remaining;

    // Output register
    logic              r_out_valid;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [WORD_W-1:0] r_src_id, n_src_id;
    logic [WORD_W-1:0] r_dest_id, n_dest_id;
    logic [OPC_W-1:0]  r_opcode, n_opcode;
    logic [SIZE_W-1:0] r_packet_len, n_packet_len;
    logic [SIZE_W-1:0] r_message_len, n_message_len;
    logic [TAG_W-1:0]  r_msg_byte, n_msg_byte;
    logic              r_last, n_last;
    logic [ERR_W-1:0]  r_error_code, n_error_code;
    logic              n_res_valid;

    logic              in_ready;
    logic              acc;
    logic              cfg_wr;
    logic [WORD_W-1:0] word_in;
    logic              word_done;

    // ------------------------------------------------------------------
    // APB
    // ------------------------------------------------------------------
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;

    always_comb begin
        o_prdata = '0;
        unique case (i_paddr[3:2])
            REG_HDR_TAG:  o_prdata[TAG_W-1:0] = r_hdr_tag;
            REG_UINT_TAG: o_prdata[TAG_W-1:0] = r_uint_tag;
            REG_STR_TAG:  o_prdata[TAG_W-1:0] = r_str_tag;
            default:      o_prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: take a byte whenever the output register is free or drains
    // ------------------------------------------------------------------
    assign in_ready     = !r_out_valid || o_res.ready;
    assign i_byte.ready = in_ready;
    assign acc          = i_byte.valid && in_ready;

    // Word gather: big-endian, newest byte at the bottom
    assign word_in   = {r_field_word, i_byte.in_byte};
    assign word_done = (r_byte_idx == IDX_W'(3));

    // ------------------------------------------------------------------
    // Next-state and result logic
    // ------------------------------------------------------------------
    always_comb begin
        n_phase       = r_phase;
        n_byte_idx    = r_byte_idx;
        n_field_word  = r_field_word;
        n_hdr_size    = r_hdr_size;
        n_hdr_opc     = r_hdr_opc;
        n_src_word    = r_src_word;
        n_dst_word    = r_dst_word;
        n_len_word    = r_len_word;
        n_remaining   = r_remaining;

        n_res_valid   = 1'b0;
        n_kind        = KIND_DESC;
        n_src_id      = '0;
        n_dest_id     = '0;
        n_opcode      = '0;
        n_packet_len  = '0;
        n_message_len = '0;
        n_msg_byte    = '0;
        n_last        = 1'b0;
        n_error_code  = '0;

        if (acc) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_byte.in_byte == r_hdr_tag) begin
                        n_phase      = PH_HDR;
                        n_byte_idx   = '0;
                        n_field_word = '0;
                    end
                end
                PH_HDR, PH_SRC, PH_DST, PH_LEN: begin
                    n_field_word = word_in[23:0];
                    n_byte_idx   = word_done ? '0 : r_byte_idx + IDX_W'(1);
                    if (word_done) begin
                        priority case (r_phase)
                            PH_HDR: begin
                                n_hdr_size = word_in[SIZE_W-1:0];
                                n_hdr_opc  = word_in[WORD_W-1:SIZE_W];
                                n_phase    = PH_TAG_SRC;
                            end
                            PH_SRC: begin
                                n_src_word = word_in;
                                n_phase    = PH_TAG_DST;
                            end
                            PH_DST: begin
                                n_dst_word = word_in;
                                n_phase    = PH_TAG_LEN;
                            end
                            default: begin
                                // Size check at 33 bits: no wrap
                                n_len_word = word_in[SIZE_W-1:0];
                                if ((WORD_W + 1)'(r_hdr_size) !=
                                    FIELD_BYTES + (WORD_W + 1)'(word_in)) begin
                                    n_res_valid  = 1'b1;
                                    n_kind       = KIND_ERR;
                                    n_last       = 1'b1;
                                    n_error_code = ERR_SIZE;
                                    n_phase      = PH_HUNT;
                                end else begin
                                    n_phase = PH_TAG_STR;
                                end
                            end
                        endcase
                    end
                end
                PH_TAG_SRC, PH_TAG_DST, PH_TAG_LEN: begin
                    if (i_byte.in_byte != r_uint_tag) begin
                        n_res_valid  = 1'b1;
                        n_kind       = KIND_ERR;
                        n_last       = 1'b1;
                        n_error_code = ERR_UINT_TAG;
                        n_phase      = PH_HUNT;
                    end else begin
                        n_byte_idx   = '0;
                        n_field_word = '0;
                        n_phase      = t_phase'(r_phase + 4'd1);
                    end
                end
                PH_TAG_STR: begin
                    n_res_valid = 1'b1;
                    if (i_byte.in_byte != r_str_tag) begin
                        n_kind       = KIND_ERR;
                        n_last       = 1'b1;
                        n_error_code = ERR_STR_TAG;
                        n_phase      = PH_HUNT;
                    end else begin
                        n_kind        = KIND_DESC;
                        n_src_id      = r_src_word;
                        n_dest_id     = r_dst_word;
                        n_opcode      = r_hdr_opc;
                        n_packet_len  = r_hdr_size;
                        n_message_len = r_len_word;
                        n_remaining   = r_len_word;
                        if (r_len_word == '0) begin
                            n_last  = 1'b1;
                            n_phase = PH_HUNT;
                        end else begin
                            n_phase = PH_MSG;
                        end
                    end
                end
                PH_MSG: begin
                    n_res_valid = 1'b1;
                    n_kind      = KIND_BYTE;
                    n_msg_byte  = i_byte.in_byte;
                    n_remaining = r_remaining - SIZE_W'(1);
                    if (r_remaining == SIZE_W'(1)) begin
                        n_last  = 1'b1;
                        n_phase = PH_HUNT;
                    end
                end
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Registers: parse state and result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_tag     <= '0;
            r_uint_tag    <= '0;
            r_str_tag     <= '0;
            r_phase       <= PH_HUNT;
            r_byte_idx    <= '0;
            r_field_word  <= '0;
            r_hdr_size    <= '0;
            r_hdr_opc     <= '0;
            r_src_word    <= '0;
            r_dst_word    <= '0;
            r_len_word    <= '0;
            r_remaining   <= '0;
            r_out_valid   <= 1'b0;
            r_kind        <= KIND_DESC;
            r_src_id      <= '0;
            r_dest_id     <= '0;
            r_opcode      <= '0;
            r_packet_len  <= '0;
            r_message_len <= '0;
            r_msg_byte    <= '0;
            r_last        <= 1'b0;
            r_error_code  <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (i_paddr[3:2])
                    REG_HDR_TAG:  r_hdr_tag  <= i_pwdata[TAG_W-1:0];
                    REG_UINT_TAG: r_uint_tag <= i_pwdata[TAG_W-1:0];
                    REG_STR_TAG:  r_str_tag  <= i_pwdata[TAG_W-1:0];
                    default: ;
                endcase
            end
            r_phase      <= n_phase;
            r_byte_idx   <= n_byte_idx;
            r_field_word <= n_field_word;
            r_hdr_size   <= n_hdr_size;
            r_hdr_opc    <= n_hdr_opc;
            r_src_word   <= n_src_word;
            r_dst_word   <= n_dst_word;
            r_len_word   <= n_len_word;
            r_remaining  <= n_remaining;
            if (in_ready) begin
                r_out_valid <= acc && n_res_valid;
            end
            if (acc && n_res_valid) begin
                r_kind        <= n_kind;
                r_src_id      <= n_src_id;
                r_dest_id     <= n_dest_id;
                r_opcode      <= n_opcode;
                r_packet_len  <= n_packet_len;
                r_message_len <= n_message_len;
                r_msg_byte    <= n_msg_byte;
                r_last        <= n_last;
                r_error_code  <= n_error_code;
            end
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.kind        = r_kind;
    assign o_res.src_id      = r_src_id;
    assign o_res.dest_id     = r_dest_id;
    assign o_res.opcode      = r_opcode;
    assign o_res.packet_len  = r_packet_len;
    assign o_res.message_len = r_message_len;
    assign o_res.msg_byte    = r_msg_byte;
    assign o_res.last        = r_last;
    assign o_res.error_code  = r_error_code;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // An error always closes the frame
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == KIND_ERR) |-> r_last)
        else $error("error result without last");

    // A result flagged last sends the parser back to hunting
    a_last_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && n_res_valid && n_last) |=> (r_phase == PH_HUNT))
        else $error("parser not hunting after last result");

    // Message phase never runs with an exhausted byte count
    a_msg_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MSG) |-> (r_remaining != '0))
        else $error("message phase with zero remaining");

    // Byte index only moves inside a word
    a_idx_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_byte_idx != '0) |-> (r_phase == PH_HDR || r_phase == PH_SRC ||
                                r_phase == PH_DST || r_phase == PH_LEN))
        else $error("byte index set outside a word");

    // Bytes are never dropped while the output register is full and stalled
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |-> !i_byte.ready)
        else $error("byte taken while result stalled");

endmodule

@@ bench/tagged_message_frame_parser_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for tagged_message_frame_parser_top: byte stream in, frame results out.
// Depends on tmfp_pkg, tmfp_byte_if, tmfp_res_if and the parser top level.
module tagged_message_frame_parser_top_tb
    import tmfp_pkg::*;
;

    localparam int CYCLE_LIMIT = 200_000;

    // Parse phases of the frame layout, in stream order.
    typedef enum logic [3:0] {
        S_HUNT, S_HEADER, S_SRC_TAG, S_SRC, S_DST_TAG, S_DST,
        S_LEN_TAG, S_LEN, S_STR_TAG, S_MSG
    } parse_phase_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] src_id;
        logic [WORD_W-1:0] dest_id;
        logic [OPC_W-1:0]  opcode;
        logic [SIZE_W-1:0] packet_len;
        logic [SIZE_W-1:0] message_len;
        logic [TAG_W-1:0]  msg_byte;
        logic              last;
        logic [ERR_W-1:0]  error_code;
    } frame_result_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_psel;
    logic                  i_penable;
    logic                  i_pwrite;
    logic [APB_ADDR_W-1:0] i_paddr;
    logic [APB_DATA_W-1:0] i_pwdata;
    logic [APB_DATA_W-1:0] o_prdata;
    logic                  o_pready;

    tmfp_byte_if byte_ch ();
    tmfp_res_if  res_ch ();

    tagged_message_frame_parser_top dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (byte_ch),
        .o_res     (res_ch),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    // Shadow copies of the tag registers
    logic [TAG_W-1:0] tag_header;
    logic [TAG_W-1:0] tag_uint;
    logic [TAG_W-1:0] tag_string;

    // Parser state as the bench sees it
    parse_phase_t      parse_phase;
    logic [1:0]        word_pos;
    logic [WORD_W-1:0] shift_word;
    logic [SIZE_W-1:0] hdr_size;
    logic [OPC_W-1:0]  hdr_opc;
    logic [WORD_W-1:0] src_w;
    logic [WORD_W-1:0] dst_w;
    logic [WORD_W-1:0] len_w;
    logic [SIZE_W-1:0] bytes_left;

    frame_result_t    pending_results[$];
    logic [TAG_W-1:0] frame_q[$];

    int  mismatches;
    int  bytes_accepted;
    int  results_checked;
    int  n_desc;
    int  n_msg;
    int  n_err;
    int  tag_settings;
    int  cycle_count;
    int  res_stall;
    bit  quiet_mode;   // no idling on either side while set

    always #1 i_clk = ~i_clk;

    // Run limit: covers the slowest legal run several times over.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tagged_message_frame_parser_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Frame predictor
    // ------------------------------------------------------------------

    // Shift one byte of a big-endian word in; true once four are in.
    function automatic bit take_stream_byte(input logic [7:0] b);
        shift_word = {shift_word[WORD_W-9:0], b};
        if (word_pos == 2'd3) begin
            word_pos = 2'd0;
            return 1'b1;
        end
        word_pos = word_pos + 2'd1;
        return 1'b0;
    endfunction

    function automatic void expect_error(input logic [ERR_W-1:0] code);
        frame_result_t r;
        r = '0;
        r.kind       = KIND_ERR;
        r.last       = 1'b1;
        r.error_code = code;
        pending_results.push_back(r);
        parse_phase = S_HUNT;
    endfunction

    function automatic void predict_frame_byte(input logic [7:0] b);
        frame_result_t r;
        r = '0;
        case (parse_phase)
            S_HUNT: begin
                if (b == tag_header) begin
                    parse_phase = S_HEADER;
                    word_pos    = 2'd0;
                    shift_word  = '0;
                end
            end
            S_HEADER: begin
                if (take_stream_byte(b)) begin
                    hdr_size    = shift_word[SIZE_W-1:0];
                    hdr_opc     = shift_word[WORD_W-1:SIZE_W];
                    parse_phase = S_SRC_TAG;
                end
            end
            S_SRC_TAG, S_DST_TAG, S_LEN_TAG: begin
                if (b != tag_uint) begin
                    expect_error(ERR_UINT_TAG);
                end else begin
                    word_pos    = 2'd0;
                    shift_word  = '0;
                    parse_phase = parse_phase_t'(4'(parse_phase + 1));
                end
            end
            S_SRC: begin
                if (take_stream_byte(b)) begin
                    src_w       = shift_word;
                    parse_phase = S_DST_TAG;
                end
            end
            S_DST: begin
                if (take_stream_byte(b)) begin
                    dst_w       = shift_word;
                    parse_phase = S_LEN_TAG;
                end
            end
            S_LEN: begin
                if (take_stream_byte(b)) begin
                    len_w = shift_word;
                    // 33-bit compare, so 12 + length cannot wrap
                    if ({5'd0, hdr_size} != ({1'b0, len_w} + 33'd12))
                        expect_error(ERR_SIZE);
                    else
                        parse_phase = S_STR_TAG;
                end
            end
            S_STR_TAG: begin
                if (b != tag_string) begin
                    expect_error(ERR_STR_TAG);
                end else begin
                    r.kind        = KIND_DESC;
                    r.src_id      = src_w;
                    r.dest_id     = dst_w;
                    r.opcode      = hdr_opc;
                    r.packet_len  = hdr_size;
                    r.message_len = len_w[SIZE_W-1:0];
                    bytes_left    = len_w[SIZE_W-1:0];
                    if (bytes_left == '0) begin
                        r.last      = 1'b1;
                        parse_phase = S_HUNT;
                    end else begin
                        parse_phase = S_MSG;
                    end
                    pending_results.push_back(r);
                end
            end
            S_MSG: begin
                r.kind     = KIND_BYTE;
                r.msg_byte = b;
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == '0) begin
                    r.last      = 1'b1;
                    parse_phase = S_HUNT;
                end
                pending_results.push_back(r);
            end
            default: parse_phase = S_HUNT;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                      results_checked, name, got, want));
    endtask

    // Result side: compare each accepted transaction, then draw the next stall.
    always @(posedge i_clk) begin
        frame_result_t want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result, kind %0d", res_ch.kind));
            end else begin
                want = pending_results.pop_front();
                check_field("kind",        res_ch.kind,        want.kind);
                check_field("src_id",      res_ch.src_id,      want.src_id);
                check_field("dest_id",     res_ch.dest_id,     want.dest_id);
                check_field("opcode",      res_ch.opcode,      want.opcode);
                check_field("packet_len",  res_ch.packet_len,  want.packet_len);
                check_field("message_len", res_ch.message_len, want.message_len);
                check_field("msg_byte",    res_ch.msg_byte,    want.msg_byte);
                check_field("last",        res_ch.last,        want.last);
                check_field("error_code",  res_ch.error_code,  want.error_code);
                case (want.kind)
                    KIND_DESC: n_desc++;
                    KIND_BYTE: n_msg++;
                    default:   n_err++;
                endcase
            end
            results_checked++;
            res_stall = quiet_mode ? 0 : $urandom_range(0, 3);
        end
    end

    // Result side back-pressure, driven on the falling edge
    always @(negedge i_clk) begin
        if (res_stall > 0) begin
            res_ch.ready <= 1'b0;
            res_stall--;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one byte after a random gap; returns on the falling edge after
    // the transaction, with valid still high so back-to-back bytes stay gapless.
    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= value;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        predict_frame_byte(value);
        bytes_accepted++;
        @(negedge i_clk);
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) send_byte(frame_q[i]);
        frame_q.delete();
    endtask

    function automatic void push_word(input logic [WORD_W-1:0] w);
        frame_q.push_back(w[31:24]);
        frame_q.push_back(w[23:16]);
        frame_q.push_back(w[15:8]);
        frame_q.push_back(w[7:0]);
    endfunction

    // Layout: [0] header tag, [1..4] header word, [5] uint tag, [6..9] source,
    // [10] uint tag, [11..14] destination, [15] uint tag, [16..19] length,
    // [20] string tag, then the message bytes.
    function automatic void build_frame(input logic [OPC_W-1:0] opc,
                                        input logic [SIZE_W-1:0] size,
                                        input logic [WORD_W-1:0] src,
                                        input logic [WORD_W-1:0] dst,
                                        input logic [WORD_W-1:0] len,
                                        input int n_msg);
        frame_q.delete();
        frame_q.push_back(tag_header);
        push_word({opc, size});
        frame_q.push_back(tag_uint);
        push_word(src);
        frame_q.push_back(tag_uint);
        push_word(dst);
        frame_q.push_back(tag_uint);
        push_word(len);
        frame_q.push_back(tag_string);
        repeat (n_msg) frame_q.push_back(8'($urandom));
    endfunction

    // A byte the hunter skips
    function automatic logic [7:0] skip_byte();
        logic [7:0] v;
        v = 8'($urandom);
        if (v == tag_header) v ^= 8'h01;
        return v;
    endfunction

    // Frame with one tag inverted, cut just after it
    task automatic send_broken_tag(input int idx);
        build_frame(4'($urandom), 28'd13, $urandom, $urandom, 32'd1, 1);
        frame_q[idx] = ~frame_q[idx];
        while (frame_q.size() > idx + 1) void'(frame_q.pop_back());
        send_frame();
    endtask

    // Feeds bytes until the parser is hunting again; wrong tags end early.
    task automatic return_to_hunt();
        logic [7:0] b;
        while (parse_phase != S_HUNT) begin
            case (parse_phase)
                S_SRC_TAG, S_DST_TAG, S_LEN_TAG: b = ~tag_uint;
                S_STR_TAG:                       b = ~tag_string;
                default:                         b = 8'($urandom);
            endcase
            send_byte(b);
        end
    endtask

    // Stop offering bytes and wait until every result has been taken.
    task automatic settle();
        byte_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic read_reg(input logic [1:0] idx, input logic [TAG_W-1:0] want);
        @(negedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        i_paddr   <= APB_ADDR_W'({idx, 2'b00});
        @(negedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        if (o_prdata !== {{(APB_DATA_W-TAG_W){1'b0}}, want})
            report_mismatch($sformatf("register %0d read %0h expected %0h",
                                      idx, o_prdata, want));
        @(negedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [TAG_W-1:0] value);
        @(negedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= APB_ADDR_W'({idx, 2'b00});
        i_pwdata  <= APB_DATA_W'(value);
        @(negedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        case (idx)
            REG_HDR_TAG:  tag_header = value;
            REG_UINT_TAG: tag_uint   = value;
            default:      tag_string = value;
        endcase
        @(negedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        read_reg(idx, value);
    endtask

    // Tags change only with the parser hunting and the result side drained.
    task automatic configure_tags(input logic [7:0] hdr, input logic [7:0] uint_t,
                                  input logic [7:0] str);
        return_to_hunt();
        settle();
        write_reg(REG_HDR_TAG, hdr);
        write_reg(REG_UINT_TAG, uint_t);
        write_reg(REG_STR_TAG, str);
        tag_settings++;
    endtask

    // Mostly well-formed frames with random content; some corrupted at one
    // byte, some pure noise.
    task automatic run_random_traffic(input int n_bytes);
        int start;
        int sel;
        int mlen;
        int pos;
        start = bytes_accepted;
        while (bytes_accepted - start < n_bytes) begin
            quiet_mode = ($urandom_range(0, 4) == 0);
            sel  = $urandom_range(0, 9);
            mlen = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                               : $urandom_range(0, 12);
            build_frame(4'($urandom), 28'(12 + mlen), $urandom, $urandom,
                        32'(mlen), mlen);
            if (sel < 7) begin
                repeat ($urandom_range(0, 2)) frame_q.push_front(skip_byte());
            end else if (sel < 9) begin
                pos = $urandom_range(1, frame_q.size() - 1);
                frame_q[pos] = 8'($urandom);
            end else begin
                frame_q.delete();
                repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom));
            end
            send_frame();
        end
        quiet_mode = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers read back zero after reset; a frame parses with all tags zero.
    task automatic test_register_reset();
        read_reg(REG_HDR_TAG, 8'h00);
        read_reg(REG_UINT_TAG, 8'h00);
        read_reg(REG_STR_TAG, 8'h00);
        tag_settings++;
        build_frame(4'h3, 28'd15, 32'h0102_0304, 32'h0506_0708, 32'd3, 3);
        send_frame();
    endtask

    task automatic test_special_cases();
        configure_tags(8'h7E, 8'h81, 8'h3C);
        // skipped while hunting
        frame_q.push_back(8'h00);
        frame_q.push_back(8'hFF);
        send_frame();
        // field extremes, two message bytes
        build_frame(4'hF, 28'd14, 32'hFFFF_FFFF, 32'h0000_0000, 32'd2, 0);
        frame_q.push_back(8'h00);
        frame_q.push_back(8'hFF);
        send_frame();
        // empty message: descriptor carries last
        build_frame(4'h0, 28'd12, 32'h0000_0000, 32'hFFFF_FFFF, 32'd0, 0);
        send_frame();
        // wrong uint tag before each field, wrong string tag
        send_broken_tag(5);
        send_broken_tag(10);
        send_broken_tag(15);
        send_broken_tag(20);
        // would match if 12 + length wrapped at 32 bits
        build_frame(4'h5, 28'h000_0000, 32'h1234_5678, 32'h9ABC_DEF0,
                    32'hFFFF_FFF4, 0);
        send_frame();
        // largest sizes, still a mismatch
        build_frame(4'hA, 28'hFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                    32'hFFFF_FFFF, 0);
        send_frame();
        return_to_hunt();
    endtask

    task automatic test_tag_extremes();
        configure_tags(8'hFF, 8'h00, 8'hFF);
        run_random_traffic(275);
        configure_tags(8'h00, 8'hFF, 8'h00);
        run_random_traffic(275);
    endtask

    task automatic test_random_tags();
        configure_tags(8'($urandom), 8'($urandom), 8'($urandom));
        run_random_traffic(275);
    endtask

    // One value serves as header, uint and string tag at once.
    task automatic test_shared_tag_value();
        logic [7:0] v;
        v = 8'($urandom);
        configure_tags(v, v, v);
        run_random_traffic(275);
    endtask

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_psel          = 1'b0;
        i_penable       = 1'b0;
        i_pwrite        = 1'b0;
        i_paddr         = '0;
        i_pwdata        = '0;
        byte_ch.valid   = 1'b0;
        byte_ch.in_byte = '0;
        res_ch.ready    = 1'b0;
        tag_header      = '0;
        tag_uint        = '0;
        tag_string      = '0;
        parse_phase     = S_HUNT;
        word_pos        = '0;
        shift_word      = '0;
        hdr_size        = '0;
        hdr_opc         = '0;
        src_w           = '0;
        dst_w           = '0;
        len_w           = '0;
        bytes_left      = '0;
        quiet_mode      = 1'b0;
        res_stall       = 0;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_register_reset();
        test_special_cases();
        test_tag_extremes();
        test_random_tags();
        test_shared_tag_value();

        return_to_hunt();
        settle();
        repeat (8) @(negedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived",
                                      pending_results.size()));

        $display("Run: %0d bytes in over %0d tag settings, %0d results checked",
                 bytes_accepted, tag_settings, results_checked);
        $display("     (%0d descriptors, %0d message bytes, %0d errors), %0d mismatches",
                 n_desc, n_msg, n_err, mismatches);
        if (mismatches == 0)
            $display("tagged_message_frame_parser_top test passed");
        else
            $display("tagged_message_frame_parser_top test failed");
        $finish;
    end

endmodule
